@@ src/rbs_pkg.sv @@
package rbs_pkg;

    // Fraction bits of every coordinate, direction and distance.
    localparam int FRAC_BITS = 16;

    // Index of the last axis (z).
    localparam logic [1:0] AX_LAST = 2'd2;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_MAX_DIST = 3'd6
    } rbs_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic [1:0] ax;
        logic       set_miss;
        logic       div_start;
        logic       ax_update;
        logic       take_hit;
        logic       mul;
        logic       pt;
        logic       finish;
    } rbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dir_zero;
        logic par_miss;
        logic div_done;
        logic miss;
        logic hit;
        logic last;
        logic out_full;
    } rbs_stat_t;

endpackage

@@ src/rbs_div.sv @@
module rbs_div #(
    parameter int CW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [CW:0]   num,
    input  logic signed [CW-1:0] den,
    output logic                 done,
    output logic signed [CW-1:0] quo
);
    import rbs_pkg::*;

    localparam int K     = CW - 1;
    localparam int N     = CW + 1 + FRAC_BITS;
    localparam int CNT_W = $clog2(K + 1);

    logic [CW-1:0]    rem_reg;
    logic [K-1:0]     low_reg;
    logic [K-1:0]     q_reg;
    logic [CW-1:0]    ud_reg;
    logic             neg_reg;
    logic             big_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [CW:0]      un;
    logic [CW-1:0]    ud;
    logic [N-1:0]     dvd;
    logic [N-1:0]     top;
    logic             big;
    logic [CW-1:0]    rem_next;
    logic [K-1:0]     low_next;
    logic [K-1:0]     q_next;
    logic [CNT_W-1:0] cnt_next;
    logic [CW:0]      r2;

    // Operand magnitudes and the saturation test on the integer part.
    always_comb
    begin
        un  = num[CW] ? (~num + 1'b1) : num;
        ud  = den[CW-1] ? (~den + 1'b1) : den;
        dvd = {un, {FRAC_BITS{1'b0}}};
        top = dvd >> K;
        big = top >= {{(N-CW){1'b0}}, ud};
    end

    // Two restoring steps per cycle.
    always_comb
    begin
        rem_next = rem_reg;
        low_next = low_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        r2       = '0;
        for (int s = 0; s < 2; s++)
        begin
            if (cnt_next != '0)
            begin
                r2       = {rem_next, low_next[K-1]};
                low_next = low_next << 1;
                if (r2 >= {1'b0, ud_reg})
                begin
                    rem_next = CW'(r2 - {1'b0, ud_reg});
                    q_next   = {q_next[K-2:0], 1'b1};
                end
                else
                begin
                    rem_next = r2[CW-1:0];
                    q_next   = {q_next[K-2:0], 1'b0};
                end
                cnt_next = cnt_next - 1'b1;
            end
        end
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(K);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_next;
                if (cnt_next == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= top[CW-1:0];
            low_reg <= dvd[K-1:0];
            q_reg   <= '0;
            ud_reg  <= ud;
            neg_reg <= num[CW] ^ den[CW-1];
            big_reg <= big;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            q_reg   <= q_next;
        end
    end

    // Signed, saturated quotient.
    always_comb
    begin
        if (big_reg)
            quo = neg_reg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        else
            quo = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    end

    assign done = done_reg;

endmodule

@@ src/rbs_ctrl.sv @@
module rbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rbs_pkg::rbs_stat_t st,
    output rbs_pkg::rbs_cmd_t  cmd
);
    import rbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AXIS,
        S_DIV,
        S_CMP,
        S_MUL,
        S_PT,
        S_FIN
    } state_t;

    state_t     state_reg;
    logic [1:0] ax_reg;

    // Commands decoded from the current state.
    always_comb
    begin
        cmd      = '0;
        cmd.ax   = ax_reg;
        s_tready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: cmd.load = s_tvalid;
            S_AXIS:
            begin
                cmd.set_miss  = !st.miss && st.dir_zero && st.par_miss;
                cmd.div_start = !st.miss && !st.dir_zero;
            end
            S_DIV:  cmd.ax_update = st.div_done;
            S_CMP:  cmd.take_hit  = st.hit;
            S_MUL:  cmd.mul       = 1'b1;
            S_PT:   cmd.pt        = 1'b1;
            S_FIN:  cmd.finish    = st.last && !st.out_full;
            default: cmd = '0;
        endcase
    end

    // State sequence: up to three axes, the compare, the hit point on a hit, the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ax_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (s_tvalid)
                    begin
                        ax_reg    <= '0;
                        state_reg <= S_AXIS;
                    end
                S_AXIS:
                    priority if (st.miss || (st.dir_zero && st.par_miss))
                        state_reg <= S_CMP;
                    else if (!st.dir_zero)
                        state_reg <= S_DIV;
                    else if (ax_reg == AX_LAST)
                        state_reg <= S_CMP;
                    else
                        ax_reg <= ax_reg + 1'b1;
                S_DIV:
                    if (st.div_done)
                    begin
                        if (ax_reg == AX_LAST)
                            state_reg <= S_CMP;
                        else
                        begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= S_AXIS;
                        end
                    end
                S_CMP:
                begin
                    ax_reg    <= '0;
                    state_reg <= st.hit ? S_MUL : S_FIN;
                end
                S_MUL: state_reg <= S_PT;
                S_PT:
                    if (ax_reg == AX_LAST)
                        state_reg <= S_FIN;
                    else
                    begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                S_FIN:
                    if (!st.last || !st.out_full)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/rbs_dp.sv @@
module rbs_dp #(
    parameter int CW = 32,
    parameter int IW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rbs_pkg::rbs_cmd_t    cmd,
    output rbs_pkg::rbs_stat_t   st,
    input  logic [2:0][CW-1:0]   origin,
    input  logic [2:0][CW-1:0]   dir,
    input  logic [CW-2:0]        max_dist,
    input  logic [2:0][CW-1:0]   local_min,
    input  logic [2:0][CW-1:0]   local_max,
    input  logic [2:0][CW-1:0]   pos,
    input  logic [IW-1:0]        object_id,
    input  logic                 last_object,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit_found,
    output logic [IW:0]          hit_id,
    output logic [2:0][CW-1:0]   hit_pt
);
    import rbs_pkg::*;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam int PW = 2 * CW + FRAC_BITS;

    function automatic logic signed [CW-1:0] sat_add(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s[CW] != s[CW-1])
            return s[CW] ? CMIN : CMAX;
        return s[CW-1:0];
    endfunction

    logic [2:0][CW-1:0]  lo_reg;
    logic [2:0][CW-1:0]  hi_reg;
    logic [IW-1:0]       id_reg;
    logic                last_reg;
    logic signed [CW-1:0] tmin_reg;
    logic signed [CW-1:0] tmax_reg;
    logic                miss_reg;
    logic signed [CW-1:0] best_dist_reg;
    logic [IW:0]         best_id_reg;
    logic                any_hit_reg;
    logic [2:0][CW-1:0]  best_pt_reg;
    logic [PW-1:0]       prod_reg;
    logic                pneg_reg;
    logic                out_valid_reg;
    logic                out_found_reg;
    logic [IW:0]         out_id_reg;
    logic [2:0][CW-1:0]  out_pt_reg;

    logic signed [CW-1:0] cur_org;
    logic signed [CW-1:0] cur_dir;
    logic signed [CW-1:0] cur_lo;
    logic signed [CW-1:0] cur_hi;
    logic signed [CW:0]   num_lo;
    logic signed [CW:0]   num_hi;
    logic                 done_lo;
    logic                 done_hi;
    logic signed [CW-1:0] q_lo;
    logic signed [CW-1:0] q_hi;
    logic signed [CW-1:0] t1;
    logic signed [CW-1:0] t2;
    logic signed [CW-1:0] nmin;
    logic signed [CW-1:0] nmax;
    logic signed [CW-1:0] bound;
    logic [CW-1:0]        dmag;
    logic [PW-1:0]        prod_next;
    logic                 over;
    logic signed [CW-1:0] mterm;

    // Operands of the axis in work.
    assign cur_org = $signed(origin[cmd.ax]);
    assign cur_dir = $signed(dir[cmd.ax]);
    assign cur_lo  = $signed(lo_reg[cmd.ax]);
    assign cur_hi  = $signed(hi_reg[cmd.ax]);
    assign num_lo  = {cur_lo[CW-1], cur_lo} - {cur_org[CW-1], cur_org};
    assign num_hi  = {cur_hi[CW-1], cur_hi} - {cur_org[CW-1], cur_org};

    // Entry and exit parameters of both slab planes, side by side.
    rbs_div #(.CW(CW)) u_div_lo (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_lo),
        .den   (cur_dir),
        .done  (done_lo),
        .quo   (q_lo)
    );

    rbs_div #(.CW(CW)) u_div_hi (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_hi),
        .den   (cur_dir),
        .done  (done_hi),
        .quo   (q_hi)
    );

    // Ordered slab interval and its intersection with the running one.
    always_comb
    begin
        t1   = (q_lo > q_hi) ? q_hi : q_lo;
        t2   = (q_lo > q_hi) ? q_lo : q_hi;
        nmin = (t1 > tmin_reg) ? t1 : tmin_reg;
        nmax = (t2 < tmax_reg) ? t2 : tmax_reg;
    end

    // Hit point term: direction times entry distance.
    always_comb
    begin
        dmag      = cur_dir[CW-1] ? (~cur_dir + 1'b1) : cur_dir;
        prod_next = PW'(dmag) * PW'(tmin_reg[CW-2:0]);
        over      = |prod_reg[PW-1:CW-1+FRAC_BITS];
        if (over)
            mterm = pneg_reg ? CMIN : CMAX;
        else
            mterm = pneg_reg ? -$signed({1'b0, prod_reg[CW-2+FRAC_BITS:FRAC_BITS]})
                             : $signed({1'b0, prod_reg[CW-2+FRAC_BITS:FRAC_BITS]});
    end

    assign bound = any_hit_reg ? best_dist_reg : $signed({1'b0, max_dist});

    always_comb
    begin
        st.dir_zero = (cur_dir == '0);
        st.par_miss = (cur_org < cur_lo) || (cur_org > cur_hi);
        st.div_done = done_lo && done_hi;
        st.miss     = miss_reg;
        st.hit      = !miss_reg && (tmin_reg < bound);
        st.last     = last_reg;
        st.out_full = out_valid_reg;
    end

    // Per-object registers, the hit point product and the result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= sat_add($signed(local_min[a]), $signed(pos[a]));
                hi_reg[a] <= sat_add($signed(local_max[a]), $signed(pos[a]));
            end
            id_reg   <= object_id;
            last_reg <= last_object;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            pneg_reg <= cur_dir[CW-1];
        end
        if (cmd.finish)
        begin
            out_found_reg <= any_hit_reg;
            out_id_reg    <= best_id_reg;
            out_pt_reg    <= best_pt_reg;
        end
    end

    // Slab interval and nearest-hit state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmin_reg      <= '0;
            tmax_reg      <= CMAX;
            miss_reg      <= 1'b0;
            best_dist_reg <= '0;
            best_id_reg   <= '1;
            any_hit_reg   <= 1'b0;
            best_pt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                tmin_reg <= '0;
                tmax_reg <= CMAX;
                miss_reg <= 1'b0;
            end
            if (cmd.set_miss)
                miss_reg <= 1'b1;
            if (cmd.ax_update)
            begin
                tmin_reg <= nmin;
                tmax_reg <= nmax;
                if (nmin > nmax)
                    miss_reg <= 1'b1;
            end
            if (cmd.take_hit)
            begin
                best_dist_reg <= tmin_reg;
                best_id_reg   <= {1'b0, id_reg};
                any_hit_reg   <= 1'b1;
            end
            if (cmd.pt)
                best_pt_reg[cmd.ax] <= sat_add(cur_org, mterm);
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                best_dist_reg <= '0;
                best_id_reg   <= '1;
                any_hit_reg   <= 1'b0;
                best_pt_reg   <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_found = out_found_reg;
    assign hit_id    = out_id_reg;
    assign hit_pt    = out_pt_reg;

    // Without a hit the stored id is minus one.
    a_no_hit_id: assert property (@(posedge clk) disable iff (!rst_n)
        !any_hit_reg |-> (best_id_reg == '1))
        else $error("best id set without a hit");

    // The entry distance never goes negative.
    a_tmin_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !tmin_reg[CW-1])
        else $error("entry distance negative");

    // A result without a hit carries id minus one.
    a_out_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_id_reg == '1))
        else $error("miss result with an id");

    // A result is loaded only into an empty output register.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_valid_reg)
        else $error("result overwritten");

endmodule

@@ src/ray_box_slab_nearest_hit.sv @@
// Nearest-hit ray test against a stream of axis-aligned boxes. The ray (origin,
// direction, maximum distance; signed Q16.16) is to be written by the user over
// the APB port only while the block is idle; the block itself does not enforce
// this. Each input beat carries one object; its world box is tested with the
// slab method, and an entry distance strictly below the best so far wins. The
// beat marked tlast produces one output beat with the hit flag in tuser and the
// id (minus one if none) and hit point in tdata, and the run state clears. One
// object is processed at a time; the test ends sooner when an axis is parallel
// or misses early. The two slab dividers produce two quotient bits per cycle,
// one axis at a time.
module ray_box_slab_nearest_hit #(
    parameter int COORD_BITS = 32,
    parameter int ID_BITS    = 16,
    localparam int PDW       = (COORD_BITS > 32) ? 64 : 32,
    localparam int SH        = (COORD_BITS > 32) ? 3 : 2,
    localparam int AW        = SH + 3,
    localparam int IN_W      = ((9 * COORD_BITS + ID_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((3 * COORD_BITS + ID_BITS + 1 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // APB configuration port.
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AW-1:0]    paddr,
    input  logic [PDW-1:0]   pwdata,
    output logic [PDW-1:0]   prdata,
    output logic             pready,
    // Object stream.
    input  logic             s_tvalid,
    output logic             s_tready,
    // local_min_x, local_min_y, local_min_z, local_max_x, local_max_y,
    // local_max_z, pos_x, pos_y, pos_z, object_id
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tlast,   // last_object
    // Result stream.
    output logic             m_tvalid,
    input  logic             m_tready,
    // hit_id, hit_x, hit_y, hit_z
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tuser    // hit_found
);
    import rbs_pkg::*;

    localparam int CW = COORD_BITS;

    logic [2:0][CW-1:0] origin_reg;
    logic [2:0][CW-1:0] dir_reg;
    logic [CW-2:0]      max_dist_reg;
    rbs_reg_t           idx;
    logic               wr;

    logic [2:0][CW-1:0] local_min;
    logic [2:0][CW-1:0] local_max;
    logic [2:0][CW-1:0] pos;
    logic [ID_BITS-1:0] object_id;
    rbs_cmd_t           cmd;
    rbs_stat_t          st;
    logic [ID_BITS:0]   hit_id;
    logic [2:0][CW-1:0] hit_pt;

    assign pready = 1'b1;
    assign idx    = rbs_reg_t'(paddr[AW-1:SH]);
    assign wr     = psel && penable && pwrite;

    // Ray registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg   <= '0;
            dir_reg      <= '0;
            max_dist_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_ORIGIN_X: origin_reg[0] <= pwdata[CW-1:0];
                REG_ORIGIN_Y: origin_reg[1] <= pwdata[CW-1:0];
                REG_ORIGIN_Z: origin_reg[2] <= pwdata[CW-1:0];
                REG_DIR_X:    dir_reg[0]    <= pwdata[CW-1:0];
                REG_DIR_Y:    dir_reg[1]    <= pwdata[CW-1:0];
                REG_DIR_Z:    dir_reg[2]    <= pwdata[CW-1:0];
                REG_MAX_DIST: max_dist_reg  <= pwdata[CW-2:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (idx)
            REG_ORIGIN_X: prdata = PDW'(origin_reg[0]);
            REG_ORIGIN_Y: prdata = PDW'(origin_reg[1]);
            REG_ORIGIN_Z: prdata = PDW'(origin_reg[2]);
            REG_DIR_X:    prdata = PDW'(dir_reg[0]);
            REG_DIR_Y:    prdata = PDW'(dir_reg[1]);
            REG_DIR_Z:    prdata = PDW'(dir_reg[2]);
            REG_MAX_DIST: prdata = PDW'(max_dist_reg);
            default:      prdata = '0;
        endcase
    end

    // Input beat fields.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            local_min[a] = s_tdata[a*CW +: CW];
            local_max[a] = s_tdata[(3+a)*CW +: CW];
            pos[a]       = s_tdata[(6+a)*CW +: CW];
        end
        object_id = s_tdata[9*CW +: ID_BITS];
    end

    rbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rbs_dp #(.CW(CW), .IW(ID_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .origin      (origin_reg),
        .dir         (dir_reg),
        .max_dist    (max_dist_reg),
        .local_min   (local_min),
        .local_max   (local_max),
        .pos         (pos),
        .object_id   (object_id),
        .last_object (s_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .hit_found   (m_tuser),
        .hit_id      (hit_id),
        .hit_pt      (hit_pt)
    );

    // Output beat packing.
    assign m_tdata = OUT_W'({hit_pt[2], hit_pt[1], hit_pt[0], hit_id});

endmodule
